// ===== rtl/gs_pkg.sv =====
// Package for the Gauss-Seidel solver: payload structs, codes, state encoding
// and the controller/datapath command and status structs.
// Depends on nothing.
package gs_pkg;

    localparam int unsigned MaxUnknownsDefault = 16;
    localparam int unsigned ResetSize          = 16;
    localparam int unsigned ResetSweeps        = 100;
    localparam int unsigned QuoWidth           = 64;

    typedef enum logic [1:0] {
        CMD_LOAD_COEF  = 2'd0,
        CMD_LOAD_RHS   = 2'd1,
        CMD_LOAD_GUESS = 2'd2,
        CMD_SOLVE      = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_SWEEP = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic [9:0]         sweeps_done;
        logic               converged;
        logic               zero_pivot;
        logic               last;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIVOT_RD,
        ST_PIVOT_CHK,
        ST_ROW_START,
        ST_ROW_RD,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_STORE,
        ST_SWEEP_END,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       rd_diag;    // read diagonal i for the pivot scan
        logic       chk_diag;   // test read diagonal against zero
        logic       row_init;   // acc := b[i] << 16, read diagonal and x[i]
        logic       rd_term;    // read A[i][j] and x[j]
        logic       mul;        // register product
        logic       acc;        // subtract product
        logic       div_start;
        logic       store;      // write x[i] and add step squared to norm
        logic       norm_clr;
        logic       rd_emit;    // read x[i] for output
        logic [5:0] i;
        logic [5:0] j;
    } t_dp_cmd;

    typedef struct packed {
        logic  diag_zero;
        logic  div_busy;
        logic  conv;
    } t_dp_stat;

endpackage

// ===== rtl/gs_divider.sv =====
// Restoring divider: 64-bit magnitude by 32-bit magnitude, one quotient bit
// per cycle, then sign and saturate to signed Q16.16.
// Depends on gs_pkg.
module gs_divider
    import gs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_busy,
    output logic signed [31:0] o_quo
);

    logic [63:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_trial;

    // One shift and trial subtract a cycle.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        w_trial = {r_rem, r_quo[63]} - {2'b00, r_den};
        if (!w_trial[33]) begin
            n_rem = w_trial[32:0];
            n_quo = {r_quo[62:0], 1'b1};
        end else begin
            n_rem = {r_rem[31:0], r_quo[63]};
            n_quo = {r_quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'(QuoWidth);
            r_quo  <= i_num[63] ? 64'(-i_num) : i_num;
            r_den  <= i_den[31] ? 32'(-i_den) : i_den;
            r_rem  <= '0;
            r_neg  <= i_num[63] ^ i_den[31];
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;

    // Sign and saturate.
    always_comb begin
        if (!r_neg) begin
            o_quo = (r_quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(r_quo);
        end else begin
            o_quo = (r_quo >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-r_quo);
        end
    end

endmodule

// ===== rtl/gs_datapath.sv =====
// Datapath: matrix, rhs and estimate memories, multiply-accumulate, divider
// and step norm. Depends on gs_pkg and gs_divider.
module gs_datapath
    import gs_pkg::*;
#(
    parameter int unsigned MAX_UNKNOWNS = MaxUnknownsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_in_beat           i_beat,
    input  t_dp_cmd            i_cmd,
    input  logic [47:0]        i_tol,
    output t_dp_stat           o_stat,
    output logic signed [31:0] o_x
);

    localparam int unsigned IW = $clog2(MAX_UNKNOWNS);

    logic signed [31:0] r_a_mem [MAX_UNKNOWNS*MAX_UNKNOWNS];
    logic signed [31:0] r_b_mem [MAX_UNKNOWNS];
    logic signed [31:0] r_x_mem [MAX_UNKNOWNS];

    logic signed [31:0] r_a_rd, r_x_rd, r_b_rd, r_diag, r_old;
    logic signed [63:0] r_prod, r_acc, n_acc;
    logic [63:0]        r_norm, n_norm;
    logic               w_busy;
    logic signed [31:0] w_quo, w_new;
    logic signed [32:0] w_d;
    logic [31:0]        w_ud;
    logic [63:0]        w_sq, w_sum;
    logic               w_sum_c;
    logic [IW-1:0]      w_i, w_j;
    logic signed [64:0] w_diff;
    logic               r_seed;

    assign w_i = i_cmd.i[IW-1:0];
    assign w_j = i_cmd.j[IW-1:0];

    // Memory writes: loads from the input channel, estimates from the sweep.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            case (t_cmd'(i_beat.cmd))
                CMD_LOAD_COEF: begin
                    if (32'(i_beat.row) < MAX_UNKNOWNS && 32'(i_beat.col) < MAX_UNKNOWNS)
                        r_a_mem[(IW*2)'(i_beat.row) * (IW*2)'(MAX_UNKNOWNS)
                                + (IW*2)'(i_beat.col)] <= i_beat.value;
                end
                CMD_LOAD_RHS: begin
                    if (32'(i_beat.row) < MAX_UNKNOWNS)
                        r_b_mem[IW'(i_beat.row)] <= i_beat.value;
                end
                CMD_LOAD_GUESS: begin
                    if (32'(i_beat.row) < MAX_UNKNOWNS)
                        r_x_mem[IW'(i_beat.row)] <= i_beat.value;
                end
                default: ;
            endcase
        end else if (i_cmd.store) begin
            r_x_mem[w_i] <= w_new;
        end
    end

    // Registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_diag || i_cmd.row_init) begin
            r_a_rd <= r_a_mem[(IW*2)'(w_i) * (IW*2)'(MAX_UNKNOWNS) + (IW*2)'(w_i)];
            r_x_rd <= r_x_mem[w_i];
            r_b_rd <= r_b_mem[w_i];
        end else if (i_cmd.rd_term) begin
            r_a_rd <= r_a_mem[(IW*2)'(w_i) * (IW*2)'(MAX_UNKNOWNS) + (IW*2)'(w_j)];
            r_x_rd <= r_x_mem[w_j];
        end else if (i_cmd.rd_emit) begin
            r_x_rd <= r_x_mem[w_i];
        end
    end

    // Saturating subtract of the product.
    always_comb begin
        w_diff = 65'(r_acc) - 65'(r_prod);
        if (w_diff[64] != w_diff[63])
            n_acc = w_diff[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else
            n_acc = w_diff[63:0];
    end

    // Step and saturating norm.
    assign w_new = (r_diag == 0) ? r_old : w_quo;
    assign w_d   = 33'(w_new) - 33'(r_old);
    assign w_ud  = w_d[32] ? 32'(-w_d) : 32'(w_d);
    assign w_sq  = 64'(w_ud) * 64'(w_ud);
    assign {w_sum_c, w_sum} = 65'(r_norm) + 65'(w_sq);
    assign n_norm = w_sum_c ? '1 : w_sum;

    // Product, accumulator and norm. The accumulator takes b[i] in Q32.32 in
    // the cycle after row entry, once the row's reads have landed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= 64'(r_a_rd) * 64'(r_x_rd);
        end
        if (r_seed) begin
            r_acc <= {{16{r_b_rd[31]}}, r_b_rd, 16'h0000};
        end else if (i_cmd.acc) begin
            r_acc <= n_acc;
        end
        if (i_cmd.norm_clr) begin
            r_norm <= '0;
        end else if (i_cmd.store) begin
            r_norm <= n_norm;
        end
    end

    // Latch the diagonal and old estimate on row entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 1'b0;
        end else begin
            r_seed <= i_cmd.row_init;
        end
        if (r_seed) begin
            r_diag <= r_a_rd;
            r_old  <= r_x_rd;
        end
    end

    gs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_acc),
        .i_den   (r_diag),
        .o_busy  (w_busy),
        .o_quo   (w_quo)
    );

    assign o_stat.diag_zero = (r_a_rd == 0);
    assign o_stat.div_busy  = w_busy;
    assign o_stat.conv      = (r_norm <= 64'(i_tol));
    assign o_x              = r_x_rd;

endmodule

// ===== rtl/gs_controller.sv =====
// Controller: sequences pivot scan, sweeps, row terms and result emission.
// Depends on gs_pkg.
module gs_controller
    import gs_pkg::*;
#(
    parameter int unsigned MAX_UNKNOWNS = MaxUnknownsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_solve,
    input  logic [4:0]  i_size,
    input  logic [9:0]  i_max_sweeps,
    input  t_dp_stat    i_stat,
    input  logic        i_out_stall,
    output logic        o_busy,
    output t_dp_cmd     o_cmd,
    output logic        o_out_valid,
    output logic [5:0]  o_index,
    output logic [9:0]  o_sweeps,
    output logic        o_conv,
    output logic        o_zp,
    output logic        o_last
);

    t_state      r_state, n_state;
    logic [5:0]  r_i, n_i, r_j, n_j, r_n, n_n;
    logic [9:0]  r_sw, n_sw;
    logic        r_conv, n_conv, r_zp, n_zp;
    logic [6:0]  w_sz;

    assign w_sz = (7'(i_size) > 7'(MAX_UNKNOWNS)) ? 7'(MAX_UNKNOWNS) : 7'(i_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i <= n_i; r_j <= n_j; r_n <= n_n;
        r_sw <= n_sw; r_conv <= n_conv; r_zp <= n_zp;
    end

    always_comb begin
        n_state = r_state;
        n_i = r_i; n_j = r_j; n_n = r_n;
        n_sw = r_sw; n_conv = r_conv; n_zp = r_zp;
        o_cmd = '0;
        o_cmd.i = r_i;
        o_cmd.j = r_j;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_solve && w_sz != 7'd0) begin
                    n_n = 6'(w_sz - 7'd1);
                    n_i = '0; n_sw = '0; n_conv = 1'b0; n_zp = 1'b0;
                    n_state = ST_PIVOT_RD;
                end
            end
            ST_PIVOT_RD: begin
                o_cmd.rd_diag = 1'b1;
                n_state = ST_PIVOT_CHK;
            end
            ST_PIVOT_CHK: begin
                if (i_stat.diag_zero) n_zp = 1'b1;
                if (r_i == r_n) begin
                    n_i = '0;
                    n_state = (i_max_sweeps == 10'd0) ? ST_EMIT_RD : ST_SWEEP_END;
                end else begin
                    n_i = r_i + 6'd1;
                    n_state = ST_PIVOT_RD;
                end
            end
            ST_SWEEP_END: begin
                // Decide whether another sweep runs.
                if (r_conv || r_sw >= i_max_sweeps) begin
                    n_i = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    o_cmd.norm_clr = 1'b1;
                    n_i = '0;
                    n_state = ST_ROW_START;
                end
            end
            ST_ROW_START: begin
                o_cmd.row_init = 1'b1;
                n_j = '0;
                n_state = ST_ROW_RD;
            end
            ST_ROW_RD: begin
                // The diagonal term is skipped; the divide starts only from ST_STORE, so
                // that the seeded accumulator and diagonal have settled.
                if (r_j == r_i) begin
                    n_j = r_j + 6'd1;
                    if (r_j == r_n) begin
                        n_state = ST_STORE;
                    end
                end else begin
                    o_cmd.rd_term = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_j = r_j + 6'd1;
                n_state = ST_ROW_RD;
                if (r_j == r_n) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.store = 1'b1;
                    if (r_i == r_n) begin
                        n_sw = r_sw + 10'd1;
                        n_state = ST_SWEEP_END;
                        n_conv = 1'b0;
                    end else begin
                        n_i = r_i + 6'd1;
                        n_state = ST_ROW_START;
                    end
                end
            end
            ST_EMIT_RD: begin
                o_cmd.rd_emit = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (r_i == r_n) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + 6'd1;
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // The norm register is final in the cycle after the last store.
        if (r_state == ST_SWEEP_END && r_sw != 10'd0 && i_stat.conv) begin
            n_conv = 1'b1;
            n_i = '0;
            n_state = ST_EMIT_RD;
            o_cmd.norm_clr = 1'b0;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_index  = r_i;
    assign o_sweeps = r_sw;
    assign o_conv   = r_conv;
    assign o_zp     = r_zp;
    assign o_last   = (r_i == r_n);

endmodule

// ===== rtl/gauss_seidel_solver.sv =====
// Gauss-Seidel solver, top level: register file, input channel, controller
// and datapath. Depends on gs_pkg, gs_controller and gs_datapath.
//
// Input channel (i_in_valid / o_in_stall) carries load beats and solve
// commands. A load beat writes one word of the matrix, rhs or estimate
// memory; while the solver is idle, loads stream at one beat per cycle.
// A solve beat starts the controller; the input channel stalls until the
// last result beat has been taken. A pivot scan reads every diagonal
// before the first sweep. In each sweep a row takes one memory read,
// multiply and saturating subtract per term, skips the diagonal, starts
// the divide, waits for the restoring divide and stores the estimate; a
// stop test follows each sweep. Results leave as n beats on o_out_valid /
// i_out_stall, each read from the estimate memory before it is offered; a
// stall holds the beat. Configuration writes (i_cfg_valid / o_cfg_ready)
// are taken while idle. Reset restores the registers; memory contents are
// undefined until loaded.
module gauss_seidel_solver
    import gs_pkg::*;
#(
    parameter int unsigned MAX_UNKNOWNS = MaxUnknownsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in_beat,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out_beat,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic [4:0]  r_size;
    logic [9:0]  r_max_sw;
    logic [47:0] r_tol;
    logic        w_busy, w_acc, w_solve, w_load;
    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    logic signed [31:0] w_x;
    logic [5:0]  w_idx;
    logic [9:0]  w_sw;
    logic        w_conv, w_zp, w_last;

    // Configuration registers.
    assign o_cfg_ready = !w_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= 5'(ResetSize);
            r_max_sw <= 10'(ResetSweeps);
            r_tol    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SIZE:  r_size   <= i_cfg_data[4:0];
                REG_SWEEP: r_max_sw <= i_cfg_data[9:0];
                REG_TOL:   r_tol    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = w_busy;
    assign w_acc   = i_in_valid && !o_in_stall;
    assign w_solve = w_acc && (t_cmd'(i_in_beat.cmd) == CMD_SOLVE);
    assign w_load  = w_acc && (t_cmd'(i_in_beat.cmd) != CMD_SOLVE);

    gs_controller #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_solve      (w_solve),
        .i_size       (r_size),
        .i_max_sweeps (r_max_sw),
        .i_stat       (w_stat),
        .i_out_stall  (i_out_stall),
        .o_busy       (w_busy),
        .o_cmd        (w_cmd),
        .o_out_valid  (o_out_valid),
        .o_index      (w_idx),
        .o_sweeps     (w_sw),
        .o_conv       (w_conv),
        .o_zp         (w_zp),
        .o_last       (w_last)
    );

    gs_datapath #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_beat  (i_in_beat),
        .i_cmd   (w_cmd),
        .i_tol   (r_tol),
        .o_stat  (w_stat),
        .o_x     (w_x)
    );

    assign o_out_beat.index       = w_idx[3:0];
    assign o_out_beat.solution    = w_x;
    assign o_out_beat.sweeps_done = w_sw;
    assign o_out_beat.converged   = w_conv;
    assign o_out_beat.zero_pivot  = w_zp;
    assign o_out_beat.last        = w_last;

    // No new item is taken while results are still owed.
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted during emission");
    // A stalled result beat holds its index.
    a_hold_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat.index))
        else $error("stalled beat changed");
    // The sweep count never passes the limit.
    a_sweep_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.sweeps_done <= r_max_sw)
        else $error("sweep count over limit");

endmodule

// ===== verif/gauss_seidel_solver_tb.sv =====
// Self-checking testbench for the Gauss-Seidel solver: directed and random load/solve
// traffic with random idling on both channels, checked against a built-in predictor.
// Depends on gs_pkg and gauss_seidel_solver.
`timescale 1ns / 1ps

module gauss_seidel_solver_tb;
    import gs_pkg::*;

    localparam int N_MAX     = 16;
    localparam int N_TEST    = 4;
    localparam int WDOG_MAX  = 600000;
    localparam int DRAIN_GAP = 20;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_beat    i_in_beat;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_beat   o_out_beat;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    // Predictor state: stores and registers as the block should hold them.
    logic signed [31:0] coef_mem [N_MAX*N_MAX];
    logic signed [31:0] rhs_mem  [N_MAX];
    logic signed [31:0] est_mem  [N_MAX];
    logic [4:0]         size_reg;
    logic [9:0]         sweep_reg;
    logic [47:0]        tol_reg;

    t_out_beat solution_q[$];
    int        n_errors;
    int        n_items;
    int        n_results;
    int        n_solves;
    int        hold_cycles;
    bit        calm_sender;
    int        idle_count;

    gauss_seidel_solver DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Row accumulator update, saturating at the 64-bit signed limits.
    function automatic longint sub_sat(longint acc, longint prod);
        logic signed [64:0] r;
        r = 65'(acc) - 65'(prod);
        if (r > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (r < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
        return r[63:0];
    endfunction

    // Q32.32 / Q16.16 quotient truncated towards zero and saturated to 32 bits.
    function automatic logic signed [31:0] div_q16(longint acc, logic signed [31:0] den);
        logic [63:0] ua;
        logic [63:0] ud;
        logic [63:0] q;
        bit          neg;
        ua  = acc < 0 ? 64'd0 - acc : acc;
        ud  = den < 0 ? 64'd0 - longint'(den) : longint'(den);
        neg = (acc < 0) != (den < 0);
        q   = ua / ud;
        if (!neg) return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
        if (q >= 64'h8000_0000) return 32'h8000_0000;
        return 32'd0 - q[31:0];
    endfunction

    // Runs the solve on the predictor's copy and queues the emitted solution.
    task automatic solve_and_queue();
        int          n;
        int          sweeps;
        bit          conv;
        bit          zp;
        logic [64:0] norm;
        longint      acc;
        longint      d;
        logic [63:0] ud;
        logic signed [31:0] nv;
        t_out_beat   b;
        n      = size_reg > N_MAX ? N_MAX : size_reg;
        sweeps = 0;
        conv   = 0;
        zp     = 0;
        if (n == 0) return;
        for (int i = 0; i < n; i++) if (coef_mem[i*N_MAX+i] == 0) zp = 1;
        while (!conv && sweeps < sweep_reg) begin
            norm = '0;
            for (int i = 0; i < n; i++) begin
                acc = longint'(rhs_mem[i]) * 65536;
                for (int j = 0; j < n; j++) begin
                    if (j != i) acc = sub_sat(acc, longint'(coef_mem[i*N_MAX+j]) *
                                                   longint'(est_mem[j]));
                end
                nv = est_mem[i];
                if (coef_mem[i*N_MAX+i] != 0) nv = div_q16(acc, coef_mem[i*N_MAX+i]);
                d  = longint'(nv) - longint'(est_mem[i]);
                ud = d < 0 ? -d : d;
                est_mem[i] = nv;
                norm = norm + ud * ud;
                if (norm[64]) norm = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
            end
            sweeps++;
            conv = norm <= {17'd0, tol_reg};
        end
        for (int i = 0; i < n; i++) begin
            b.index       = i[3:0];
            b.solution    = est_mem[i];
            b.sweeps_done = sweeps[9:0];
            b.converged   = conv;
            b.zero_pivot  = zp;
            b.last        = (i == n - 1);
            solution_q.push_back(b);
        end
        n_solves++;
    endtask

    // Sends one beat on the input channel and applies it to the predictor.
    task automatic send_beat(t_cmd cmd, int row, int col, logic [31:0] value);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_beat  <= '{cmd: cmd, row: row[3:0], col: col[3:0], value: value};
        do @(posedge i_clk); while (o_in_stall);
        n_items++;
        case (cmd)
            CMD_LOAD_COEF:  coef_mem[row*N_MAX+col] = value;
            CMD_LOAD_RHS:   rhs_mem[row] = value;
            CMD_LOAD_GUESS: est_mem[row] = value;
            CMD_SOLVE:      solve_and_queue();
            default: ;
        endcase
        gap = calm_sender ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Withdraws any offered beat, then waits for every expected result.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (solution_q.size() == 0);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    // Register write; only issued once the block has gone quiet.
    task automatic write_reg(logic [1:0] idx, logic [47:0] data);
        wait_drained();
        @(negedge i_clk);
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SIZE:  size_reg  = data[4:0];
            REG_SWEEP: sweep_reg = data[9:0];
            REG_TOL:   tol_reg   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(int n, int sweeps, logic [47:0] tol);
        write_reg(REG_SIZE, 48'(n));
        write_reg(REG_SWEEP, 48'(sweeps));
        write_reg(REG_TOL, tol);
    endtask

    // Small random Q16.16 value for well-conditioned systems.
    function automatic logic [31:0] small_val();
        return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endfunction

    // Every entry that a solve can reach is written first, so no solve reads
    // an unset word; solves keep to the first N_TEST unknowns.
    task automatic test_init_stores();
        for (int r = 0; r < N_TEST; r++) begin
            for (int c = 0; c < N_TEST; c++)
                send_beat(CMD_LOAD_COEF, r, c,
                          r == c ? (40 << 16) : $signed(small_val()) >>> 2);
            send_beat(CMD_LOAD_RHS, r, 0, small_val());
            send_beat(CMD_LOAD_GUESS, r, 0, 32'd0);
        end
    endtask

    // Extremes of the fields and registers, zero pivots, size and limit corners.
    task automatic test_directed();
        configure(1, 1, 48'hFFFF_FFFF_FFFF);
        send_beat(CMD_SOLVE, 15, 15, 32'hFFFF_FFFF);
        configure(N_TEST, 2, 48'd0);
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
        // Extreme words drive the quotient into saturation.
        configure(2, 1, 48'd0);
        send_beat(CMD_LOAD_COEF, 0, 1, 32'h8000_0000);
        send_beat(CMD_LOAD_GUESS, 1, 0, 32'h7FFF_FFFF);
        send_beat(CMD_LOAD_COEF, 0, 0, 32'h0000_0001);
        send_beat(CMD_LOAD_RHS, 0, 0, 32'h7FFF_FFFF);
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
        send_beat(CMD_LOAD_COEF, 0, 0, 32'hFFFF_FFFF);
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
        send_beat(CMD_LOAD_COEF, 0, 0, 40 << 16);
        send_beat(CMD_LOAD_COEF, 0, 1, 1 << 16);
        send_beat(CMD_LOAD_GUESS, 1, 0, 32'd0);
        // A zero diagonal keeps the estimate and raises the pivot flag.
        configure(3, 2, 48'd0);
        send_beat(CMD_LOAD_COEF, 1, 1, 32'd0);
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
        send_beat(CMD_LOAD_COEF, 1, 1, 40 << 16);
        // No sweeps at all, and size zero.
        configure(4, 0, 48'd0);
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
        configure(0, 3, 48'd0);
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
    endtask

    // Random phases: the settings, loads inside the active size, then two solves.
    task automatic test_random();
        int          n;
        int          r;
        logic [47:0] tol;
        for (int ph = 0; ph < 5; ph++) begin
            n = $urandom_range(1, N_TEST);
            r = $urandom_range(0, 2);
            tol = r == 0 ? 48'd0 : r == 1 ? 48'($urandom_range(0, 65535)) :
                  48'({$urandom(), $urandom()});
            configure(n, $urandom_range(1, 12), tol);
            for (int k = 0; k < 9; k++) begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    send_beat(CMD_LOAD_COEF, $urandom_range(0, n-1), $urandom_range(0, n-1),
                              $urandom_range(0, 9) == 0 ? $urandom() : small_val());
                else if (r < 8)
                    send_beat(CMD_LOAD_RHS, $urandom_range(0, n-1), $urandom_range(0, 15),
                              $urandom_range(0, 4) == 0 ? $urandom() : small_val());
                else
                    send_beat(CMD_LOAD_GUESS, $urandom_range(0, n-1), $urandom_range(0, 15),
                              $urandom_range(0, 4) == 0 ? $urandom() : small_val());
            end
            send_beat(CMD_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
            send_beat(CMD_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
        end
    endtask

    // Largest sweep limit on a small system, plus an ignored register index.
    task automatic test_sweep_limit();
        configure(2, 1023, 48'd0);
        write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
    endtask

    // The receiver holds off while loads queue behind a solve.
    task automatic test_backpressure();
        configure(3, 4, 48'd0);
        hold_cycles = 2000;
        calm_sender = 1;
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
        for (int k = 0; k < 6; k++)
            send_beat(CMD_LOAD_RHS, $urandom_range(0, 2), 0, small_val());
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
        calm_sender = 0;
        // The sender now waits for every beat before offering the next solve.
        wait_drained();
        send_beat(CMD_SOLVE, 0, 0, 32'd0);
    endtask

    // Output stall: a requested hold-off first, otherwise random runs.
    initial begin
        int run;
        bit level;
        i_out_stall = 1'b0;
        run = 0;
        level = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else begin
                if (run == 0) begin
                    level = $urandom_range(0, 2) == 0;
                    run = level ? pick_gap() + 1 : $urandom_range(1, 30);
                end
                run--;
                i_out_stall <= level;
            end
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Checks every result beat against the oldest expected one.
    initial begin
        t_out_beat w;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                n_results++;
                if (solution_q.size() == 0) begin
                    report_mismatch("unexpected beat, index", o_out_beat.index, -1);
                end else begin
                    w = solution_q.pop_front();
                    if (o_out_beat.index != w.index)
                        report_mismatch("index", o_out_beat.index, w.index);
                    if (o_out_beat.solution != w.solution)
                        report_mismatch("solution", o_out_beat.solution, w.solution);
                    if (o_out_beat.sweeps_done != w.sweeps_done)
                        report_mismatch("sweeps_done", o_out_beat.sweeps_done, w.sweeps_done);
                    if (o_out_beat.converged != w.converged)
                        report_mismatch("converged", o_out_beat.converged, w.converged);
                    if (o_out_beat.zero_pivot != w.zero_pivot)
                        report_mismatch("zero_pivot", o_out_beat.zero_pivot, w.zero_pivot);
                    if (o_out_beat.last != w.last)
                        report_mismatch("last", o_out_beat.last, w.last);
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    initial begin
        idle_count = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WDOG_MAX) begin
                $display("[gauss_seidel_solver] ERROR");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_beat   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        n_errors = 0;
        n_items = 0;
        n_results = 0;
        n_solves = 0;
        hold_cycles = 0;
        calm_sender = 0;
        size_reg  = 5'(ResetSize);
        sweep_reg = 10'(ResetSweeps);
        tol_reg   = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_init_stores();
        test_directed();
        test_random();
        test_sweep_limit();
        test_backpressure();

        wait_drained();
        if (solution_q.size() != 0)
            report_mismatch("leftover expected beats", 0, solution_q.size());
        $display("Covered %0d input beats, %0d solves and %0d solution beats,",
                 n_items, n_solves, n_results);
        $display("including pivot, size, sweep-limit and back-pressure corners.");
        if (n_errors == 0) begin
            $display("[gauss_seidel_solver] OK");
        end else begin
            $display("[gauss_seidel_solver] ERROR");
        end
        $finish;
    end

endmodule
